@@ rtl/leaky_pid_duty_controller_unit_macros.svh @@
// Assertion macros used by the checker file lpdc_checker.sv.
`ifndef LEAKY_PID_DUTY_CONTROLLER_UNIT_MACROS_SVH
`define LEAKY_PID_DUTY_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle property under clock ck, disabled while rn is low.
`define LPDC_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// Condition in one cycle implies the consequence in the next.
`define LPDC_ASSERT_NEXT(lbl, ck, rn, cond, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (cons)) else $error(msg);

`endif

@@ rtl/lpdc_pkg.sv @@
package lpdc_pkg;

  // Payload widths
  localparam int ADC_W      = 10;
  localparam int ON_TIME_W  = 14;
  localparam int DRIVE_W    = 23;
  localparam int ERR_W      = 27;
  localparam int INTEG_W    = 32;
  localparam int SLOPE_W    = 28;
  localparam int PREV_W     = 11;
  localparam int DEG_W      = 11;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int SETPT_W    = 9;
  localparam int BIAS_W     = 8;
  localparam int DECAY_W    = 16;
  localparam int GAIN_W     = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KI       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KD       = 3'd5;

  localparam logic [SETPT_W-1:0] SETPT_RST = 9'd225;
  localparam logic [BIAS_W-1:0]  BIAS_RST  = 8'd15;
  localparam logic [DECAY_W-1:0] DECAY_RST = 16'd58982;
  localparam logic [GAIN_W-1:0]  KP_RST    = 24'd98304;
  localparam logic [GAIN_W-1:0]  KI_RST    = 24'd1311;
  localparam logic [GAIN_W-1:0]  KD_RST    = 24'd655360;

  // Shared multiplier: signed A x unsigned B
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 24;
  localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;
  localparam int SUM_W   = PROD_W + 1;

  // Conversion and output constants
  localparam int unsigned TEMP_OFFSET_DEG = 41;
  localparam int unsigned TEMP_SLOPE_Q    = 20539;      // 0.3134 in Q0.16
  localparam int unsigned PERIOD_UNITS    = 10000;
  localparam int unsigned ON_TIME_MAX     = 16383;
  localparam int unsigned ON_TIME_FULL    =
    (PERIOD_UNITS > ON_TIME_MAX) ? ON_TIME_MAX : PERIOD_UNITS;
  localparam logic [DRIVE_W-1:0] FULL_DRIVE = 23'd6553600;  // 100.0 in Q7.16
  localparam logic signed [SUM_W-1:0] FULL_SUM = 58'sd429496729600;

  // floor(t/100) = (t*ON_RECIP) >> ON_RECIP_SHIFT, exact while t*76 < 2^30
  localparam int unsigned ON_RECIP_SHIFT = 30;
  localparam int unsigned ON_RECIP       = ((2 ** ON_RECIP_SHIFT) + 99) / 100;

endpackage

@@ rtl/leaky_pid_duty_controller_unit.sv @@
// Leaky PID heater duty controller, one shared 32x24 multiplier under a sequencer.
// A sample takes 7 multiplier passes plus sum, clamp and finish steps up to out_valid.
// in_stall is high while the sequencer runs; a new sample is taken only when idle.
// A finished result waits in the output register; the next sample runs meanwhile.
// Reset (rst_n low, synchronous): registers back to defaults, integral 0, prev error -1.
module leaky_pid_duty_controller_unit
  import lpdc_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ADC_W-1:0]            in_adc_sample,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ON_TIME_W-1:0]        out_on_time,
  output logic [DRIVE_W-1:0]          out_drive_pct,
  output logic signed [ERR_W-1:0]     out_error_now,
  output logic signed [INTEG_W-1:0]   out_error_sum,
  output logic signed [SLOPE_W-1:0]   out_error_slope,
  // configuration port
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  // One state per multiplier pass plus the accumulate/clamp/finish steps.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MTEMP,    // adc * slope
    ST_MLEAK,    // err ready; integral * decay
    ST_MPROP,    // integral, slope ready; err * kp
    ST_MINTEG,   // integral * ki
    ST_MDERIV,   // slope * kd
    ST_SUM,      // last partial into the accumulator
    ST_CLAMP,    // clamp to 0..100 percent
    ST_MON,      // drive * period
    ST_MRECIP,   // (drive*period >> 16) * reciprocal of 100
    ST_FINISH    // load output register, update state
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [SETPT_W-1:0] setpt_r;
  logic [BIAS_W-1:0]  bias_r;
  logic [DECAY_W-1:0] decay_r;
  logic [GAIN_W-1:0]  kp_r;
  logic [GAIN_W-1:0]  ki_r;
  logic [GAIN_W-1:0]  kd_r;

  // Controller state carried between samples
  logic signed [INTEG_W-1:0] acc_r;
  logic signed [PREV_W-1:0]  prev_r;

  // Working registers of the current transaction
  logic [ADC_W-1:0]          adc_r;
  logic signed [ERR_W-1:0]   err_r;
  logic signed [INTEG_W-1:0] integ_r;
  logic signed [SLOPE_W-1:0] slope_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic [DRIVE_W-1:0]        drive_r;
  logic signed [PROD_W-1:0]  prod_r;

  // Output register
  logic                      out_valid_r;
  logic [ON_TIME_W-1:0]      out_on_time_r;
  logic [DRIVE_W-1:0]        out_drive_r;
  logic signed [ERR_W-1:0]   out_err_r;
  logic signed [INTEG_W-1:0] out_integ_r;
  logic signed [SLOPE_W-1:0] out_slope_r;

  // Shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic                      mul_en;
  logic signed [PROD_W-1:0]  prod_nxt;

  // Combinational step results
  logic signed [DEG_W-1:0]   base_deg;
  logic signed [ERR_W-1:0]   err_nxt;
  logic signed [INTEG_W+1:0] integ_wide;
  logic signed [INTEG_W-1:0] integ_nxt;
  logic signed [SLOPE_W-1:0] slope_nxt;
  logic signed [SUM_W-1:0]   sum_nxt;
  logic [DRIVE_W-1:0]        drive_nxt;
  logic [ON_TIME_W+2:0]      on_quot;
  logic [ON_TIME_W-1:0]      on_time_nxt;
  logic signed [PREV_W-1:0]  prev_nxt;
  logic                      accept_in;
  logic                      out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept_in = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // Operand select for the one multiplier; the product is registered in the multiplier states.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (state_r)
      ST_MTEMP: begin
        mul_a = {{(MUL_A_W-ADC_W){1'b0}}, adc_r};
        mul_b = MUL_B_W'(TEMP_SLOPE_Q);
      end
      ST_MLEAK: begin
        mul_a = acc_r;
        mul_b = {{(MUL_B_W-DECAY_W){1'b0}}, decay_r};
      end
      ST_MPROP: begin
        mul_a = {{(MUL_A_W-ERR_W){err_r[ERR_W-1]}}, err_r};
        mul_b = kp_r;
      end
      ST_MINTEG: begin
        mul_a = integ_r;
        mul_b = ki_r;
      end
      ST_MDERIV: begin
        mul_a = {{(MUL_A_W-SLOPE_W){slope_r[SLOPE_W-1]}}, slope_r};
        mul_b = kd_r;
      end
      ST_MON: begin
        mul_a = {{(MUL_A_W-DRIVE_W){1'b0}}, drive_r};
        mul_b = MUL_B_W'(PERIOD_UNITS);
      end
      ST_MRECIP: begin
        // drive*period < 2^39, so bits [38:16] hold the whole value >> 16
        mul_a = {{(MUL_A_W-DRIVE_W){1'b0}}, prod_r[DRIVE_W+15:16]};
        mul_b = MUL_B_W'(ON_RECIP);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign prod_nxt = mul_a * $signed({1'b0, mul_b});

  // err = (setpoint + bias - 41) * 2^16 - adc * slope
  assign base_deg = $signed({2'b00, setpt_r})
                  + $signed({{(DEG_W-BIAS_W){bias_r[BIAS_W-1]}}, bias_r})
                  - DEG_W'(TEMP_OFFSET_DEG);
  assign err_nxt  = $signed({base_deg, 16'h0000}) - $signed(prod_r[ERR_W-1:0]);

  // Leak product floored by the arithmetic shift, plus the error, then saturated to 32 bits.
  assign integ_wide = $signed({prod_r[48], prod_r[48:16]})
                    + $signed({{(INTEG_W+2-ERR_W){err_r[ERR_W-1]}}, err_r});
  always_comb begin
    if (integ_wide[INTEG_W+1:INTEG_W-1] == 3'b000 ||
        integ_wide[INTEG_W+1:INTEG_W-1] == 3'b111) begin
      integ_nxt = integ_wide[INTEG_W-1:0];
    end else if (integ_wide[INTEG_W+1]) begin
      integ_nxt = {1'b1, {(INTEG_W-1){1'b0}}};
    end else begin
      integ_nxt = {1'b0, {(INTEG_W-1){1'b1}}};
    end
  end

  assign slope_nxt = $signed({err_r[ERR_W-1], err_r})
                   - $signed({prev_r[PREV_W-1], prev_r, 16'h0000});

  assign sum_nxt = sum_r + $signed({prod_r[PROD_W-1], prod_r});

  // Clamp: positive and below full scale keeps the Q7.16 drive
  always_comb begin
    if (sum_r <= 0) begin
      drive_nxt = '0;
    end else if (sum_r >= FULL_SUM) begin
      drive_nxt = FULL_DRIVE;
    end else begin
      drive_nxt = sum_r[DRIVE_W+15:16];
    end
  end

  // Quotient by 100 from the reciprocal product; product < 2^47
  assign on_quot     = prod_r[ON_RECIP_SHIFT+ON_TIME_W+2:ON_RECIP_SHIFT];
  assign on_time_nxt = (on_quot > (ON_TIME_W+3)'(ON_TIME_MAX)) ?
                       ON_TIME_W'(ON_TIME_MAX) : on_quot[ON_TIME_W-1:0];

  // Previous error in whole degrees, truncated toward zero
  assign prev_nxt = err_r[ERR_W-1:16]
                  + PREV_W'(err_r[ERR_W-1] && (err_r[15:0] != 16'h0000));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      setpt_r     <= SETPT_RST;
      bias_r      <= BIAS_RST;
      decay_r     <= DECAY_RST;
      kp_r        <= KP_RST;
      ki_r        <= KI_RST;
      kd_r        <= KD_RST;
      acc_r       <= '0;
      prev_r      <= '1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SETPOINT: setpt_r <= cfg_data[SETPT_W-1:0];
          CFG_BIAS:     bias_r  <= cfg_data[BIAS_W-1:0];
          CFG_DECAY:    decay_r <= cfg_data[DECAY_W-1:0];
          CFG_KP:       kp_r    <= cfg_data[GAIN_W-1:0];
          CFG_KI:       ki_r    <= cfg_data[GAIN_W-1:0];
          CFG_KD:       kd_r    <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end

      // in ST_FINISH the next result takes the register instead
      if (out_valid_r && !out_stall && state_r != ST_FINISH) begin
        out_valid_r <= 1'b0;
      end

      if (mul_en) begin
        prod_r <= prod_nxt;
      end

      case (state_r)
        ST_IDLE: begin
          if (accept_in) begin
            adc_r   <= in_adc_sample;
            state_r <= ST_MTEMP;
          end
        end
        ST_MTEMP:  state_r <= ST_MLEAK;
        ST_MLEAK: begin
          err_r   <= err_nxt;
          state_r <= ST_MPROP;
        end
        ST_MPROP: begin
          integ_r <= integ_nxt;
          slope_r <= slope_nxt;
          state_r <= ST_MINTEG;
        end
        ST_MINTEG: begin
          sum_r   <= $signed({prod_r[PROD_W-1], prod_r});
          state_r <= ST_MDERIV;
        end
        ST_MDERIV: begin
          sum_r   <= sum_nxt;
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          sum_r   <= sum_nxt;
          state_r <= ST_CLAMP;
        end
        ST_CLAMP: begin
          drive_r <= drive_nxt;
          state_r <= ST_MON;
        end
        ST_MON:    state_r <= ST_MRECIP;
        ST_MRECIP: state_r <= ST_FINISH;
        ST_FINISH: begin
          // hold here while the previous result is still stalled
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_on_time_r <= on_time_nxt;
            out_drive_r   <= drive_r;
            out_err_r     <= err_r;
            out_integ_r   <= integ_r;
            out_slope_r   <= slope_r;
            acc_r         <= integ_r;
            prev_r        <= prev_nxt;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_on_time     = out_on_time_r;
  assign out_drive_pct   = out_drive_r;
  assign out_error_now   = out_err_r;
  assign out_error_sum   = out_integ_r;
  assign out_error_slope = out_slope_r;

endmodule

@@ rtl/lpdc_checker.sv @@
`include "leaky_pid_duty_controller_unit_macros.svh"

module lpdc_checker
  import lpdc_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [ON_TIME_W-1:0]      out_on_time,
  input logic [DRIVE_W-1:0]        out_drive_pct,
  input logic signed [INTEG_W-1:0] out_error_sum
);

  // sequencer is busy right after taking a sample
  `LPDC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "not busy after input transaction")

  // stalled result holds
  `LPDC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_drive_pct) && $stable(out_error_sum) && $stable(out_on_time), "stalled result changed")

  `LPDC_ASSERT(a_drive_range, clk, rst_n, !out_valid || (out_drive_pct <= FULL_DRIVE), "drive above full scale")

  `LPDC_ASSERT(a_zero_drive, clk, rst_n, !out_valid || (out_drive_pct != '0) || (out_on_time == '0), "on-time nonzero at zero drive")

  `LPDC_ASSERT(a_full_drive, clk, rst_n, !out_valid || (out_drive_pct != FULL_DRIVE) || (out_on_time == ON_TIME_W'(ON_TIME_FULL)), "on-time wrong at full drive")

endmodule

bind leaky_pid_duty_controller_unit lpdc_checker u_lpdc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_on_time   (out_on_time),
  .out_drive_pct (out_drive_pct),
  .out_error_sum (out_error_sum)
);

@@ tb/leaky_pid_duty_controller_unit_tb.sv @@
module leaky_pid_duty_controller_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpdc_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 10;
  // Roughly one sample time through the sequencer.
  localparam int SETTLE_CYCLES  = 16;
  // Idle cycles (nothing accepted on either channel) before the run is called hung.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_PRINTS     = 40;

  // Indexes 6 and 7 decode to no register; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  localparam longint INTEG_MAX = 64'sd2147483647;
  localparam longint INTEG_MIN = -64'sd2147483648;

  // One result transaction, laid out as the output ports.
  typedef struct packed {
    logic [ON_TIME_W-1:0] on_time;
    logic [DRIVE_W-1:0]   drive;
    logic [ERR_W-1:0]     err;
    logic [INTEG_W-1:0]   integ;
    logic [SLOPE_W-1:0]   slope;
  } duty_result_t;

  // Every DUT input starts at a known value.
  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic [ADC_W-1:0]      in_adc_sample = '0;
  logic                  out_stall     = 1'b0;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  logic                       in_stall;
  logic                       out_valid;
  logic [ON_TIME_W-1:0]       out_on_time;
  logic [DRIVE_W-1:0]         out_drive_pct;
  logic signed [ERR_W-1:0]    out_error_now;
  logic signed [INTEG_W-1:0]  out_error_sum;
  logic signed [SLOPE_W-1:0]  out_error_slope;

  // Controller state as the testbench sees it: register copies plus the loop state.
  logic [SETPT_W-1:0]        cur_setpoint = SETPT_RST;
  logic signed [BIAS_W-1:0]  cur_bias     = BIAS_RST;
  logic [DECAY_W-1:0]        cur_decay    = DECAY_RST;
  logic [GAIN_W-1:0]         cur_kp       = KP_RST;
  logic [GAIN_W-1:0]         cur_ki       = KI_RST;
  logic [GAIN_W-1:0]         cur_kd       = KD_RST;
  int                        last_err_deg = -1;   // previous error, whole degrees
  int                        integ_acc    = 0;    // leaky integral, Q16.16

  duty_result_t pending_duty[$];   // expected results, oldest first

  int idle_pct     = 0;   // sender: chance per cycle of holding back
  int stall_pct    = 0;   // receiver: chance per cycle of stalling
  int idle_cycles  = 0;
  int n_errors     = 0;
  int n_sent       = 0;
  int n_checked    = 0;
  int n_settings   = 0;
  int n_clamp_low  = 0;
  int n_clamp_high = 0;
  int n_integ_sat  = 0;

  leaky_pid_duty_controller_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_adc_sample   (in_adc_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_on_time     (out_on_time),
    .out_drive_pct   (out_drive_pct),
    .out_error_now   (out_error_now),
    .out_error_sum   (out_error_sum),
    .out_error_slope (out_error_slope),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Duty prediction for one sample. Advances the loop state, so call it once per
  // accepted input, in acceptance order. All math in 64-bit signed: the largest
  // term is a 24-bit gain times a saturated 32-bit integral, well under 2^63.
  // ---------------------------------------------------------------------------
  function automatic duty_result_t compute_duty(input logic [ADC_W-1:0] adc);
    duty_result_t r;
    longint temp_q, err_q, integ_q, slope_q, sum_q, drive_q, on_q;
    // thermocouple reading to degrees, Q16.16
    temp_q = longint'(TEMP_OFFSET_DEG) * 65536 + longint'(adc) * longint'(TEMP_SLOPE_Q);
    err_q  = (longint'(cur_setpoint) + longint'(cur_bias)) * 65536 - temp_q;
    // leak product floors toward minus infinity, then the integral saturates
    integ_q = ((longint'(integ_acc) * longint'(cur_decay)) >>> 16) + err_q;
    if (integ_q > INTEG_MAX) integ_q = INTEG_MAX;
    if (integ_q < INTEG_MIN) integ_q = INTEG_MIN;
    if (integ_q == INTEG_MAX || integ_q == INTEG_MIN) n_integ_sat++;
    // slope against the previous error in whole degrees
    slope_q = err_q - longint'(last_err_deg) * 65536;
    // gains are Q8.16, so the sum is Q32; 100 percent is FULL_SUM
    sum_q = longint'(cur_kp) * err_q + longint'(cur_ki) * integ_q
          + longint'(cur_kd) * slope_q;
    if (sum_q <= 0) begin
      drive_q = 0;
      on_q    = 0;
      n_clamp_low++;
    end else if (sum_q >= longint'(FULL_SUM)) begin
      drive_q = longint'(FULL_DRIVE);
      on_q    = longint'(PERIOD_UNITS);
      n_clamp_high++;
    end else begin
      drive_q = sum_q >>> 16;
      on_q    = drive_q * longint'(PERIOD_UNITS) / longint'(FULL_DRIVE);
    end
    if (on_q > longint'(ON_TIME_MAX)) on_q = longint'(ON_TIME_MAX);
    integ_acc    = int'(integ_q);
    last_err_deg = int'(err_q / 65536);   // truncates toward zero
    r.on_time = on_q[ON_TIME_W-1:0];
    r.drive   = drive_q[DRIVE_W-1:0];
    r.err     = err_q[ERR_W-1:0];
    r.integ   = integ_q[INTEG_W-1:0];
    r.slope   = slope_q[SLOPE_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    n_errors++;
    if (n_errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation.
  // Ports are read at the edge, before the DUT's own updates land.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    duty_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got.on_time = out_on_time;
      got.drive   = out_drive_pct;
      got.err     = out_error_now;
      got.integ   = out_error_sum;
      got.slope   = out_error_slope;
      if (pending_duty.size() == 0) begin
        report_mismatch("result transaction with no sample outstanding");
      end else begin
        want = pending_duty.pop_front();
        if (got.on_time !== want.on_time)
          report_mismatch($sformatf("#%0d on_time got %0d want %0d",
                                    n_checked, got.on_time, want.on_time));
        if (got.drive !== want.drive)
          report_mismatch($sformatf("#%0d drive_pct got %0d want %0d",
                                    n_checked, got.drive, want.drive));
        if (got.err !== want.err)
          report_mismatch($sformatf("#%0d error_now got %0d want %0d",
                                    n_checked, $signed(got.err), $signed(want.err)));
        if (got.integ !== want.integ)
          report_mismatch($sformatf("#%0d error_sum got %0d want %0d",
                                    n_checked, $signed(got.integ), $signed(want.integ)));
        if (got.slope !== want.slope)
          report_mismatch($sformatf("#%0d error_slope got %0d want %0d",
                                    n_checked, $signed(got.slope), $signed(want.slope)));
      end
      n_checked++;
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // Watchdog: too long without a transaction on either channel means a hang.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles = idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, pending_duty.size());
      $display("[leaky_pid_duty_controller_unit] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One sample transaction. Valid is left high on return so back-to-back
  // samples need no second assignment in the same step.
  task automatic send_sample(input logic [ADC_W-1:0] adc);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_adc_sample <= adc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_duty.push_back(compute_duty(adc));
    n_sent++;
  endtask

  // Close the input, wait out every result, then give the sequencer time to go idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_duty.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write of a batch.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_SETPOINT: cur_setpoint = data[SETPT_W-1:0];
      CFG_BIAS:     cur_bias     = data[BIAS_W-1:0];
      CFG_DECAY:    cur_decay    = data[DECAY_W-1:0];
      CFG_KP:       cur_kp       = data[GAIN_W-1:0];
      CFG_KI:       cur_ki       = data[GAIN_W-1:0];
      CFG_KD:       cur_kd       = data[GAIN_W-1:0];
      default:      ;
    endcase
  endtask

  // Full register set. Bits above the setpoint, bias and decay widths carry junk: they must be dropped.
  task automatic load_settings(input logic [SETPT_W-1:0] sp, input logic [BIAS_W-1:0] bi,
                               input logic [DECAY_W-1:0] dc, input logic [GAIN_W-1:0] kp,
                               input logic [GAIN_W-1:0] ki, input logic [GAIN_W-1:0] kd);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'($urandom);
    word[SETPT_W-1:0] = sp;
    write_reg(CFG_SETPOINT, word);
    word = CFG_DATA_W'($urandom);
    word[BIAS_W-1:0] = bi;
    write_reg(CFG_BIAS, word);
    word = CFG_DATA_W'($urandom);
    word[DECAY_W-1:0] = dc;
    write_reg(CFG_DECAY, word);
    write_reg(CFG_KP, kp);
    write_reg(CFG_KI, ki);
    write_reg(CFG_KD, kd);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return GAIN_W'($urandom_range(0, 1 << 19));   // up to 8.0
    endcase
  endfunction

  function automatic logic [DECAY_W-1:0] pick_decay();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return DECAY_W'($urandom);
    endcase
  endfunction

  function automatic logic [SETPT_W-1:0] pick_setpoint();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return SETPT_W'($urandom);
    endcase
  endfunction

  // Mostly readings near the target temperature, where the drive sits between its
  // clamps; the rest anywhere on the converter range.
  function automatic logic [ADC_W-1:0] pick_adc();
    longint t;
    if ($urandom_range(3) == 0) return ADC_W'($urandom);
    t = ((longint'(cur_setpoint) + longint'(cur_bias) - longint'(TEMP_OFFSET_DEG)) * 65536)
        / longint'(TEMP_SLOPE_Q);
    t = t + longint'($urandom_range(96)) - 48;
    if (t < 0) t = 0;
    if (t > (1 << ADC_W) - 1) t = (1 << ADC_W) - 1;
    return t[ADC_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Power-on registers, integral at zero and previous error at minus one degree.
  task automatic test_reset_defaults();
    idle_pct  = 25;
    stall_pct = 25;
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'h2AA);
    send_sample(10'h155);
    send_sample(10'd635);   // near the default target
    drain_results();
  endtask

  // Drive pinned at full scale, pinned at zero, and back in the linear range.
  task automatic test_drive_clamps();
    load_settings(9'd511, 8'sd127, DECAY_RST, '1, KI_RST, KD_RST);
    send_sample(10'd0);
    send_sample(10'd0);
    drain_results();
    load_settings(9'd0, 8'h80, DECAY_RST, '1, '1, '1);
    send_sample(10'd1023);
    send_sample(10'd1023);
    drain_results();
    load_settings(SETPT_RST, BIAS_RST, DECAY_RST, KP_RST, KI_RST, KD_RST);
    send_sample(10'd630);
    send_sample(10'd640);
    send_sample(10'd635);
    drain_results();
  endtask

  // Writes to the undecoded indexes must leave the register file alone.
  task automatic test_register_decode();
    load_settings(9'd300, 8'hF0, 16'h8000, 24'h010000, 24'h000800, 24'h020000);
    @(posedge clk);
    write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    send_sample(10'd820);
    send_sample(10'd830);
    send_sample(10'd700);
    drain_results();
  endtask

  // Negative integral through the leak: decay zero (nothing kept), near-full retention, floor rounding.
  task automatic test_leak_rounding();
    load_settings(SETPT_RST, BIAS_RST, 16'd0, KP_RST, KI_RST, KD_RST);
    send_sample(10'd1023);
    send_sample(10'd1023);
    drain_results();
    load_settings(SETPT_RST, BIAS_RST, 16'hFFFF, KP_RST, KI_RST, KD_RST);
    send_sample(10'd1023);
    send_sample(10'd1001);
    send_sample(10'd900);
    drain_results();
  endtask

  // Pump the integral into its upper limit, then drag it all the way to the lower one.
  task automatic test_integral_saturation();
    idle_pct  = 32;
    stall_pct = 32;
    load_settings(9'd511, 8'sd127, 16'hFFFF, KP_RST, KI_RST, KD_RST);
    repeat (80) send_sample(ADC_W'($urandom_range(0, 31)));
    drain_results();
    load_settings(9'd0, 8'h80, 16'hFFFF, pick_gain(), pick_gain(), pick_gain());
    repeat (160) send_sample(ADC_W'($urandom_range(960, 1023)));
    drain_results();
  endtask

  // Random settings and samples under one sender/receiver pacing.
  task automatic run_phase(input int sender_idle, input int receiver_stall);
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    repeat (4) begin
      load_settings(pick_setpoint(), BIAS_W'($urandom), pick_decay(),
                    pick_gain(), pick_gain(), pick_gain());
      repeat (42) send_sample(pick_adc());
      drain_results();
    end
  endtask

  task automatic test_random_traffic();
    run_phase(0, 0);
    run_phase(88, 0);
    run_phase(0, 88);
    run_phase(32, 32);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_drive_clamps();
    test_register_decode();
    test_leak_rounding();
    test_integral_saturation();
    test_random_traffic();

    $display("run: %0d samples sent, %0d results checked, %0d register sets loaded",
             n_sent, n_checked, n_settings);
    $display("run: drive clamped low %0d / high %0d times, integral at a limit %0d times",
             n_clamp_low, n_clamp_high, n_integ_sat);
    if (n_errors == 0) begin
      $display("[leaky_pid_duty_controller_unit] OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("[leaky_pid_duty_controller_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/lpdc_pkg.sv
rtl/leaky_pid_duty_controller_unit.sv
rtl/lpdc_checker.sv
tb/leaky_pid_duty_controller_unit_tb.sv
